FILE: rtl/pwmdcs_pkg.sv
// Package for the PWM duty-cycle sampler: widths, reset values, register
// indexes, controller states and the command/status types. No dependencies.
package pwmdcs_pkg;

  localparam int CountWidth    = 16;
  localparam int FracBits      = 16;
  localparam int IntervalWidth = 24;
  localparam int WindowWidth   = 16;
  localparam int TotalWidth    = CountWidth + 1;
  localparam int NumWidth      = CountWidth + FracBits + 1;
  localparam int QuotWidth     = FracBits + 1;
  localparam int IterWidth     = $clog2(QuotWidth);
  localparam int AddrWidth     = 4;
  localparam int DataWidth     = 32;

  localparam logic [WindowWidth-1:0]   WindowReset   = WindowWidth'(100);
  localparam logic [IntervalWidth-1:0] IntervalReset = IntervalWidth'(1000);

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic step;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } sts_t;

endpackage

FILE: rtl/pwmdcs_if.sv
// Channel interfaces for the PWM duty-cycle sampler: one for tick beats and
// one for result beats. Depends on pwmdcs_pkg.
interface pwmdcs_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic level_valid;

  modport source (output valid, output pin_level, output level_valid, input ready);
  modport sink (input valid, input pin_level, input level_valid, output ready);
endinterface

interface pwmdcs_out_if import pwmdcs_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [QuotWidth-1:0]  duty_fraction;
  logic [CountWidth-1:0] high_samples;

  modport source (output valid, output duty_fraction, output high_samples, input ready);
  modport sink (input valid, input duty_fraction, input high_samples, output ready);
endinterface

FILE: rtl/pwmdcs_ctrl.sv
// Controller for the PWM duty-cycle sampler: takes tick beats, sequences the
// iterative divide and owns the result valid flag. Depends on pwmdcs_pkg.
module pwmdcs_ctrl import pwmdcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e          state_q, state_d;
  logic [IterWidth-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          if (sts_i.emit) begin
            state_d = ST_DIV;
            cnt_d   = '0;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == IterWidth'(QuotWidth - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pwmdcs_dp.sv
// Datapath for the PWM duty-cycle sampler: interval counter, saturating
// sample counts, restoring divider and result register. Depends on pwmdcs_pkg.
module pwmdcs_dp import pwmdcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     enable_i,
  input  logic                     clr_elapsed_i,
  input  logic [WindowWidth-1:0]   window_size_i,
  input  logic [IntervalWidth-1:0] sample_interval_i,
  input  logic                     pin_level_i,
  input  logic                     level_valid_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic [QuotWidth-1:0]     duty_fraction_o,
  output logic [CountWidth-1:0]    high_samples_o
);

  logic [IntervalWidth-1:0] elapsed_q, elapsed_d;
  logic [CountWidth-1:0]    high_q, high_d, low_q, low_d;
  logic [TotalWidth-1:0]    rem_q, rem_d;
  logic [TotalWidth-1:0]    div_q, div_d;
  logic [QuotWidth-1:0]     quot_q, quot_d;
  logic [CountWidth-1:0]    hs_q, hs_d;
  logic [QuotWidth-1:0]     duty_out_q;
  logic [CountWidth-1:0]    hs_out_q;

  logic                     run;
  logic [IntervalWidth-1:0] elapsed_inc, interval;
  logic                     sample;
  logic [CountWidth-1:0]    high_new, low_new;
  logic [TotalWidth-1:0]    total, window;
  logic                     emit;
  logic [NumWidth-1:0]      num;
  logic [TotalWidth:0]      trial, diff;

  always_comb begin
    run         = cmd_i.step && enable_i;
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    interval    = (sample_interval_i == '0) ? IntervalWidth'(1) : sample_interval_i;
    sample      = elapsed_inc >= interval;
    high_new    = high_q;
    low_new     = low_q;
    if (sample && level_valid_i) begin
      if (pin_level_i) begin
        if (high_q != '1) high_new = high_q + 1'b1;
      end else begin
        if (low_q != '1) low_new = low_q + 1'b1;
      end
    end
    total  = {1'b0, high_new} + {1'b0, low_new};
    window = (window_size_i == '0) ? TotalWidth'(1) : {1'b0, window_size_i};
    emit   = run && sample && (total != '0) && (total >= window);
    num    = (NumWidth'(high_new) << FracBits) + NumWidth'(total >> 1);

    trial = {rem_q, quot_q[QuotWidth-1]};
    diff  = trial - {1'b0, div_q};

    elapsed_d = elapsed_q;
    high_d    = high_q;
    low_d     = low_q;
    rem_d     = rem_q;
    div_d     = div_q;
    quot_d    = quot_q;
    hs_d      = hs_q;

    if (clr_elapsed_i) begin
      elapsed_d = '0;
    end else if (run) begin
      elapsed_d = sample ? '0 : elapsed_inc;
    end
    if (run && sample) begin
      high_d = emit ? '0 : high_new;
      low_d  = emit ? '0 : low_new;
    end
    if (emit) begin
      rem_d  = TotalWidth'(num[NumWidth-1:QuotWidth]);
      quot_d = num[QuotWidth-1:0];
      div_d  = total;
      hs_d   = high_new;
    end else if (cmd_i.div_step) begin
      if (!diff[TotalWidth]) begin
        rem_d  = diff[TotalWidth-1:0];
        quot_d = {quot_q[QuotWidth-2:0], 1'b1};
      end else begin
        rem_d  = trial[TotalWidth-1:0];
        quot_d = {quot_q[QuotWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      high_q    <= '0;
      low_q     <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      high_q    <= high_d;
      low_q     <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
    hs_q   <= hs_d;
    if (cmd_i.load_out) begin
      duty_out_q <= quot_q;
      hs_out_q   <= hs_q;
    end
  end

  assign sts_o.emit      = emit;
  assign duty_fraction_o = duty_out_q;
  assign high_samples_o  = hs_out_q;

endmodule

FILE: rtl/pwm_duty_cycle_sampler.sv
// A tick that closes a window raises result valid once the divide (ST_DIV) and the
// result load (ST_DONE) are through; other ticks finish in the cycle they are accepted.
// Throughput: one tick per cycle; after a window closes the input stalls for the
// 17-step restoring divider and the result load, longer while a result waits.
// Reset clears enable, counters and valid flags; window_size resets to 100 and
// sample_interval to 1000. Depends on pwmdcs_pkg, pwmdcs_if, ctrl and dp.
module pwm_duty_cycle_sampler import pwmdcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pwmdcs_in_if.sink            in_i,
  pwmdcs_out_if.source         out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  logic                     enable_q, enable_d;
  logic [WindowWidth-1:0]   window_q, window_d;
  logic [IntervalWidth-1:0] interval_q, interval_d;
  logic                     wr_en, clr_elapsed;
  reg_idx_e                 reg_idx;
  cmd_t                     cmd;
  sts_t                     sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    enable_d    = enable_q;
    window_d    = window_q;
    interval_d  = interval_q;
    clr_elapsed = 1'b0;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE: begin
          enable_d    = pwdata[0];
          clr_elapsed = pwdata[0] && !enable_q;
        end
        REG_WINDOW:   window_d   = pwdata[WindowWidth-1:0];
        REG_INTERVAL: interval_d = pwdata[IntervalWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      window_q   <= WindowReset;
      interval_q <= IntervalReset;
    end else begin
      enable_q   <= enable_d;
      window_q   <= window_d;
      interval_q <= interval_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:   prdata = DataWidth'(enable_q);
      REG_WINDOW:   prdata = DataWidth'(window_q);
      REG_INTERVAL: prdata = DataWidth'(interval_q);
      default:      prdata = '0;
    endcase
  end

  pwmdcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pwmdcs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .enable_i          (enable_q),
    .clr_elapsed_i     (clr_elapsed),
    .window_size_i     (window_q),
    .sample_interval_i (interval_q),
    .pin_level_i       (in_i.pin_level),
    .level_valid_i     (in_i.level_valid),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .duty_fraction_o   (out_o.duty_fraction),
    .high_samples_o    (out_o.high_samples)
  );

endmodule

FILE: verif/tb_pwm_duty_cycle_sampler.sv
// Testbench for pwm_duty_cycle_sampler: streams tick beats, programs the APB
// registers between phases and checks every result beat against a predictor.
// Depends on pwmdcs_pkg, pwmdcs_if and the sampler RTL.
module tb_pwm_duty_cycle_sampler;
  import pwmdcs_pkg::*;

  typedef struct packed {
    logic level;
    logic level_ok;
  } tick_t;

  typedef struct packed {
    logic [QuotWidth-1:0]  duty;
    logic [CountWidth-1:0] high;
  } window_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  pwmdcs_in_if  tick_if ();
  pwmdcs_out_if window_if ();

  pwm_duty_cycle_sampler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_if),
    .out_o   (window_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tick_t   tick_queue[$];
  window_t pending_windows[$];
  tick_t   next_tick;
  int      fault_count = 0;
  bit      calm = 1'b0;
  bit      tick_busy = 1'b0;
  int      tick_gap = 0;
  int      window_stall = 0;
  logic    tick_taken = 1'b0;
  logic    window_taken = 1'b0;

  logic                     run_en;
  logic [WindowWidth-1:0]   window_cfg;
  logic [IntervalWidth-1:0] interval_cfg;
  logic [IntervalWidth-1:0] elapsed;
  logic [CountWidth-1:0]    high_cnt;
  logic [CountWidth-1:0]    low_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("pwm_duty_cycle_sampler regression: fail");
    $finish;
  end

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic sample_tick(input logic level, input logic level_ok);
    logic [IntervalWidth-1:0] span;
    logic [WindowWidth-1:0]   need;
    logic [TotalWidth-1:0]    total;
    logic [NumWidth-1:0]      num;
    window_t                  res;
    if (!run_en) return;
    if (elapsed != '1) elapsed = elapsed + 1'b1;
    span = (interval_cfg == '0) ? IntervalWidth'(1) : interval_cfg;
    if (elapsed < span) return;
    elapsed = '0;
    if (level_ok && level && high_cnt != '1) high_cnt = high_cnt + 1'b1;
    if (level_ok && !level && low_cnt != '1) low_cnt = low_cnt + 1'b1;
    total = TotalWidth'(high_cnt) + TotalWidth'(low_cnt);
    need = (window_cfg == '0) ? WindowWidth'(1) : window_cfg;
    if (total == '0 || total < TotalWidth'(need)) return;
    num = (NumWidth'(high_cnt) << FracBits) + NumWidth'(total >> 1);
    res.duty = QuotWidth'(num / NumWidth'(total));
    res.high = high_cnt;
    pending_windows = {pending_windows, res};
    high_cnt = '0;
    low_cnt = '0;
  endtask

  task automatic note_fault(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    fault_count++;
    if (fault_count <= 10) $display("%s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_window(input logic [QuotWidth-1:0] duty,
                              input logic [CountWidth-1:0] high);
    window_t want;
    if (pending_windows.size() == 0) begin
      note_fault("unexpected result beat, duty_fraction", '0, 32'(duty));
      return;
    end
    want = pending_windows.pop_front();
    if (duty !== want.duty) note_fault("duty_fraction", 32'(want.duty), 32'(duty));
    if (high !== want.high) note_fault("high_samples", 32'(want.high), 32'(high));
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataWidth-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrWidth'(idx) << 2;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_ENABLE: begin
        if (value[0] != run_en) begin
          run_en = value[0];
          if (value[0]) elapsed = '0;
        end
      end
      REG_WINDOW: window_cfg = value[WindowWidth-1:0];
      REG_INTERVAL: interval_cfg = value[IntervalWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic level, input logic level_ok);
    tick_t t;
    t.level = level;
    t.level_ok = level_ok;
    tick_queue = {tick_queue, t};
  endtask

  // Lets every queued tick go out and every predicted window come back,
  // then leaves room for a divide that may still be in flight.
  task automatic settle();
    while (tick_queue.size() != 0 || tick_busy || pending_windows.size() != 0)
      @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      tick_taken <= tick_if.valid && tick_if.ready;
      window_taken <= window_if.valid && window_if.ready;
      if (tick_if.valid && tick_if.ready)
        sample_tick(tick_if.pin_level, tick_if.level_valid);
      if (window_if.valid && window_if.ready)
        check_window(window_if.duty_fraction, window_if.high_samples);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tick_taken) tick_busy = 1'b0;
      if (!tick_busy) begin
        if (tick_gap > 0) begin
          tick_gap--;
          tick_if.valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          next_tick = tick_queue.pop_front();
          tick_if.pin_level <= next_tick.level;
          tick_if.level_valid <= next_tick.level_ok;
          tick_if.valid <= 1'b1;
          tick_busy = 1'b1;
          tick_gap = draw_wait();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (window_taken) window_stall = draw_wait();
      else if (window_stall > 0 && window_if.valid) window_stall--;
      window_if.ready <= (window_stall == 0);
    end
  end

  initial begin : stimulus
    int                   random_ticks;
    int                   n;
    logic [DataWidth-1:0] win;
    logic [DataWidth-1:0] ivl;
    random_ticks = 0;
    run_en = 1'b0;
    window_cfg = WindowReset;
    interval_cfg = IntervalReset;
    elapsed = '0;
    high_cnt = '0;
    low_cnt = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_if.valid = 1'b0;
    tick_if.pin_level = 1'b0;
    tick_if.level_valid = 1'b0;
    window_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    settle();

    write_reg(REG_INTERVAL, 1);
    write_reg(REG_WINDOW, 1);
    write_reg(REG_ENABLE, 1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    settle();

    write_reg(REG_WINDOW, 3);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    settle();

    write_reg(REG_INTERVAL, 0);
    write_reg(REG_WINDOW, 0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    settle();

    write_reg(REG_INTERVAL, 3);
    write_reg(REG_WINDOW, 65535);
    repeat (6) push_tick(1'($urandom_range(0, 1)), 1'b1);
    settle();

    // Lowering the window to the running total closes it on the next sample.
    write_reg(REG_WINDOW, 2);
    repeat (3) push_tick(1'b0, 1'b0);
    settle();

    write_reg(REG_ENABLE, 0);
    push_tick(1'b1, 1'b1);
    settle();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_ENABLE, 1);
    write_reg(REG_INTERVAL, 32'hFF_FFFF);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    settle();
    write_reg(REG_INTERVAL, 2);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    settle();

    while (random_ticks < 850) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: win = 0;
        7: win = $urandom_range(13, 40);
        8: win = 65535;
        9: win = $urandom_range(0, 65535);
        default: win = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0: ivl = 0;
        1: ivl = 1;
        8: ivl = $urandom_range(5, 30);
        9: ivl = $urandom_range(0, 24'hFF_FFFF);
        default: ivl = $urandom_range(1, 4);
      endcase
      write_reg(REG_WINDOW, win);
      write_reg(REG_INTERVAL, ivl);
      write_reg(REG_ENABLE, DataWidth'($urandom_range(0, 7) != 0));
      n = $urandom_range(20, 120);
      repeat (n) begin
        push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) != 0));
        random_ticks++;
      end
      settle();
    end

    if (fault_count == 0 && pending_windows.size() == 0) begin
      $display("pwm_duty_cycle_sampler regression: pass");
    end else begin
      $display("pwm_duty_cycle_sampler regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pwmdcs_pkg.sv
rtl/pwmdcs_if.sv
rtl/pwmdcs_ctrl.sv
rtl/pwmdcs_dp.sv
rtl/pwm_duty_cycle_sampler.sv
verif/tb_pwm_duty_cycle_sampler.sv
